// ===== design/text_terminal_grid_core_assert.svh =====
// Assertion macros used by the text terminal grid back end.
// Users must have clk and rst_n in scope where the macros are expanded.
`ifndef TEXT_TERMINAL_GRID_CORE_ASSERT_SVH
`define TEXT_TERMINAL_GRID_CORE_ASSERT_SVH

// Same-cycle implication.
`define TTG_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TTG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ttg_pkg.sv =====
// Shared types, constants and the byte classifier of the text terminal grid.
// Used by every module of the block but ttg_ram; depends on nothing.
package ttg_pkg;

    localparam int DEF_MAX_COLUMNS = 128;
    localparam int DEF_MAX_ROWS    = 64;
    localparam int RESET_COLUMNS   = 80;
    localparam int RESET_ROWS      = 25;
    localparam int ACT_COL_W       = 8;
    localparam int ACT_ROW_W       = 7;
    localparam int OUT_DATA_W      = 88;
    localparam int IN_DATA_W       = 24;

    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_QUERY = 3'd2;
    localparam logic [2:0] OP_MARK  = 3'd3;
    localparam logic [2:0] OP_INIT  = 3'd4;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    localparam logic [1:0] CFG_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;

    typedef enum logic [3:0] {
        CLS_CR,
        CLS_LF,
        CLS_BS,
        CLS_FF,
        CLS_TAB,
        CLS_PRINT,
        CLS_DROP,
        CLS_READ,
        CLS_QUERY,
        CLS_MARK,
        CLS_INIT,
        CLS_NOP
    } ttg_class_t;

    typedef struct packed {
        ttg_class_t  cls;
        logic [7:0]  data_byte;
        logic [5:0]  target_row;
        logic [6:0]  target_column;
    } ttg_item_t;

    function automatic ttg_class_t classify(input logic [2:0] op, input logic [7:0] b);
        ttg_class_t c;
        c = CLS_NOP;
        case (op)
            OP_WRITE:
            begin
                case (b)
                    CH_CR:   c = CLS_CR;
                    CH_LF:   c = CLS_LF;
                    CH_BS:   c = CLS_BS;
                    CH_FF:   c = CLS_FF;
                    CH_TAB:  c = CLS_TAB;
                    default: c = (b >= CH_SPACE && b < CH_DEL) ? CLS_PRINT : CLS_DROP;
                endcase
            end
            OP_READ:  c = CLS_READ;
            OP_QUERY: c = CLS_QUERY;
            OP_MARK:  c = CLS_MARK;
            OP_INIT:  c = CLS_INIT;
            default:  c = CLS_NOP;
        endcase
        return c;
    endfunction

endpackage

// ===== design/ttg_ram.sv =====
// Generic single-port-write, registered-read RAM.
// Stand-alone; used for the character store.
module ttg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/ttg_front.sv =====
// Front end: accepts input beats, classifies them and queues them.
// Depends on ttg_pkg.
module ttg_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,
    input  logic [2:0]           s_tuser,
    output ttg_pkg::ttg_item_t   head,
    output logic                 head_valid,
    input  logic                 pop
);

    ttg_pkg::ttg_item_t q_reg [2];
    logic [1:0]         count_reg;
    logic               rd_ptr_reg;
    logic               wr_ptr_reg;
    logic               push;
    ttg_pkg::ttg_item_t new_item;

    assign s_tready   = (count_reg != 2'd2);
    assign push       = s_tvalid && s_tready;
    assign head       = q_reg[rd_ptr_reg];
    assign head_valid = (count_reg != 2'd0);

    always_comb
    begin
        new_item.cls           = ttg_pkg::classify(s_tuser, s_tdata[7:0]);
        new_item.data_byte     = s_tdata[7:0];
        new_item.target_row    = s_tdata[13:8];
        new_item.target_column = s_tdata[20:14];
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== design/ttg_back.sv =====
// Back end: sequencer that carries out queued items on the grid and drives results.
// Depends on ttg_pkg, ttg_ram and the assertion macro header.
`include "text_terminal_grid_core_assert.svh"

module ttg_back #(
    parameter int MAX_COLUMNS = ttg_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = ttg_pkg::DEF_MAX_ROWS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ttg_pkg::ttg_item_t              item,
    input  logic                            item_valid,
    output logic                            item_pop,
    input  logic [7:0]                      grid_columns,
    input  logic [6:0]                      grid_rows,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ttg_pkg::OUT_DATA_W-1:0]  m_tdata
);

    localparam int CW  = $clog2(MAX_COLUMNS);
    localparam int CXW = $clog2(MAX_COLUMNS + 1);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int AW  = RW + CW;
    localparam int RST_COLS = (ttg_pkg::RESET_COLUMNS > MAX_COLUMNS) ?
                              MAX_COLUMNS : ttg_pkg::RESET_COLUMNS;
    localparam int RST_ROWS = (ttg_pkg::RESET_ROWS > MAX_ROWS) ?
                              MAX_ROWS : ttg_pkg::RESET_ROWS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SWEEP,
        ST_PRINT,
        ST_TAB,
        ST_WRAP,
        ST_CLEAR
    } state_t;

    state_t             state_reg, state_next;
    ttg_pkg::ttg_item_t item_reg, item_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [CXW-1:0]     col_reg, col_next;
    logic [31:0]        scrolls_reg, scrolls_next;
    logic [31:0]        bytes_reg, bytes_next;
    logic [7:0]         act_cols_reg, act_cols_next;
    logic [6:0]         act_rows_reg, act_rows_next;
    logic [RW-1:0]      off_reg, off_next;
    logic [MAX_ROWS-1:0] blank_reg, blank_next;
    logic [MAX_ROWS-1:0] dirty_reg, dirty_next;
    logic [CW-1:0]      sweep_reg, sweep_next;
    logic [RW-1:0]      clr_reg, clr_next;
    logic               out_valid_reg, out_valid_next;
    logic [ttg_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [7:0]         ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [7:0]         ram_rdata;

    // Logical rows sit in the memory rotated by the row offset, modulo the active rows.
    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] r, input logic [RW-1:0] off,
                                               input logic [6:0] rows);
        logic [7:0] sum;
        sum = 8'(r) + 8'(off);
        if (sum >= {1'b0, rows})
        begin
            sum = sum - {1'b0, rows};
        end
        return RW'(sum);
    endfunction

    ttg_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ROWS << CW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        logic [RW-1:0]  phys_cur;
        logic [RW-1:0]  trow_i;
        logic           row_ok;
        logic           col_ok;
        logic           finish;
        logic           move_down;
        logic           mark_after;
        logic [7:0]     cell_v;
        logic           dirty_v;
        logic [CXW-1:0] col_inc;
        logic [RW-1:0]  last_row;

        state_next     = state_reg;
        item_next      = item_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        scrolls_next   = scrolls_reg;
        bytes_next     = bytes_reg;
        act_cols_next  = act_cols_reg;
        act_rows_next  = act_rows_reg;
        off_next       = off_reg;
        blank_next     = blank_reg;
        dirty_next     = dirty_reg;
        sweep_next     = sweep_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        item_pop       = 1'b0;
        finish         = 1'b0;
        move_down      = 1'b0;
        mark_after     = 1'b0;
        cell_v         = 8'd0;
        dirty_v        = 1'b0;
        col_inc        = col_reg + CXW'(1);
        last_row       = RW'(act_rows_reg - 7'd1);
        phys_cur       = phys_row(row_reg, off_reg, act_rows_reg);
        trow_i         = RW'(item_reg.target_row);
        row_ok         = 1'b0;
        col_ok         = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = {phys_cur, CW'(col_reg)};
        ram_wdata      = ttg_pkg::CH_SPACE;
        ram_raddr      = {phys_row(trow_i, off_reg, act_rows_reg),
                          CW'(item_reg.target_column)};

        case (state_reg)
            ST_IDLE:
            begin
                trow_i    = RW'(item.target_row);
                row_ok    = (7'(item.target_row) < act_rows_reg);
                col_ok    = (8'(item.target_column) < act_cols_reg);
                ram_raddr = {phys_row(trow_i, off_reg, act_rows_reg),
                             CW'(item.target_column)};
                if (item_valid && (!out_valid_reg || m_tready))
                begin
                    item_pop  = 1'b1;
                    item_next = item;
                    if (item.cls inside {ttg_pkg::CLS_CR, ttg_pkg::CLS_LF, ttg_pkg::CLS_BS,
                                         ttg_pkg::CLS_FF, ttg_pkg::CLS_TAB,
                                         ttg_pkg::CLS_PRINT, ttg_pkg::CLS_DROP})
                    begin
                        bytes_next = bytes_reg + 32'd1;
                    end
                    case (item.cls)
                        ttg_pkg::CLS_CR:
                        begin
                            col_next           = '0;
                            dirty_next[row_reg] = 1'b1;
                            finish             = 1'b1;
                        end
                        ttg_pkg::CLS_LF:
                        begin
                            dirty_next[row_reg] = 1'b1;
                            col_next           = '0;
                            move_down          = 1'b1;
                            mark_after         = 1'b1;
                            finish             = 1'b1;
                        end
                        ttg_pkg::CLS_BS:
                        begin
                            if (col_reg != '0)
                            begin
                                col_next            = col_reg - CXW'(1);
                                dirty_next[row_reg] = 1'b1;
                            end
                            else if (row_reg != '0)
                            begin
                                row_next = row_reg - RW'(1);
                                col_next = CXW'(act_cols_reg - 8'd1);
                                dirty_next[row_reg - RW'(1)] = 1'b1;
                            end
                            else
                            begin
                                dirty_next[row_reg] = 1'b1;
                            end
                            finish = 1'b1;
                        end
                        ttg_pkg::CLS_FF:
                        begin
                            row_next   = '0;
                            col_next   = '0;
                            clr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        ttg_pkg::CLS_TAB:
                        begin
                            state_next = ST_TAB;
                        end
                        ttg_pkg::CLS_PRINT:
                        begin
                            sweep_next = '0;
                            state_next = blank_reg[phys_cur] ? ST_SWEEP : ST_PRINT;
                        end
                        ttg_pkg::CLS_READ:
                        begin
                            if (row_ok && col_ok)
                            begin
                                state_next = ST_READ;
                            end
                            else
                            begin
                                finish = 1'b1;
                            end
                        end
                        ttg_pkg::CLS_QUERY:
                        begin
                            dirty_v = row_ok && dirty_reg[trow_i];
                            finish  = 1'b1;
                        end
                        ttg_pkg::CLS_MARK:
                        begin
                            if (row_ok)
                            begin
                                dirty_next[trow_i] = 1'b0;
                            end
                            finish = 1'b1;
                        end
                        ttg_pkg::CLS_INIT:
                        begin
                            if (grid_columns != 8'd0 &&
                                {1'b0, grid_columns} <= 9'(MAX_COLUMNS) &&
                                grid_rows != 7'd0 &&
                                {1'b0, grid_rows} <= 8'(MAX_ROWS))
                            begin
                                act_cols_next = grid_columns;
                                act_rows_next = grid_rows;
                                row_next      = '0;
                                col_next      = '0;
                                off_next      = '0;
                                scrolls_next  = '0;
                                bytes_next    = '0;
                                clr_next      = '0;
                                state_next    = ST_CLEAR;
                            end
                            else
                            begin
                                finish = 1'b1;
                            end
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                cell_v = blank_reg[phys_row(trow_i, off_reg, act_rows_reg)] ?
                         ttg_pkg::CH_SPACE : ram_rdata;
                finish = 1'b1;
            end
            ST_SWEEP:
            begin
                ram_we     = 1'b1;
                ram_waddr  = {phys_cur, sweep_reg};
                sweep_next = sweep_reg + CW'(1);
                if (sweep_reg == CW'(MAX_COLUMNS - 1))
                begin
                    blank_next[phys_cur] = 1'b0;
                    state_next           = ST_PRINT;
                end
            end
            ST_PRINT:
            begin
                ram_we              = 1'b1;
                ram_wdata           = item_reg.data_byte;
                dirty_next[row_reg] = 1'b1;
                col_next            = col_inc;
                state_next          = ST_WRAP;
            end
            ST_TAB:
            begin
                ram_we   = 1'b1;
                col_next = col_inc;
                if (!(9'(col_inc) < {1'b0, act_cols_reg} && col_inc[2:0] != 3'd0))
                begin
                    dirty_next[row_reg] = 1'b1;
                    state_next          = ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                if (9'(col_reg) >= {1'b0, act_cols_reg})
                begin
                    col_next   = '0;
                    move_down  = 1'b1;
                    mark_after = 1'b1;
                end
                finish = 1'b1;
            end
            ST_CLEAR:
            begin
                blank_next[clr_reg] = 1'b1;
                dirty_next[clr_reg] = 1'b1;
                clr_next            = clr_reg + RW'(1);
                if (clr_reg == last_row)
                begin
                    finish = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (move_down)
        begin
            if (8'(row_reg) + 8'd1 < {1'b0, act_rows_reg})
            begin
                row_next = row_reg + RW'(1);
                if (mark_after)
                begin
                    dirty_next[row_reg + RW'(1)] = 1'b1;
                end
            end
            else
            begin
                for (int r = 0; r < MAX_ROWS; r++)
                begin
                    if (r < int'(act_rows_reg))
                    begin
                        dirty_next[r] = 1'b1;
                    end
                end
                off_next            = phys_row(RW'(1), off_reg, act_rows_reg);
                blank_next[off_reg] = 1'b1;
                scrolls_next        = scrolls_reg + 32'd1;
            end
        end

        if (finish)
        begin
            state_next     = ST_IDLE;
            out_valid_next = 1'b1;
            out_data_next  = {2'b00, bytes_next, scrolls_next, 7'(col_next),
                              6'(row_next), dirty_v, cell_v};
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            scrolls_reg   <= '0;
            bytes_reg     <= '0;
            act_cols_reg  <= 8'(RST_COLS);
            act_rows_reg  <= 7'(RST_ROWS);
            off_reg       <= '0;
            blank_reg     <= '1;
            dirty_reg     <= '1;
            sweep_reg     <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            scrolls_reg   <= scrolls_next;
            bytes_reg     <= bytes_next;
            act_cols_reg  <= act_cols_next;
            act_rows_reg  <= act_rows_next;
            off_reg       <= off_next;
            blank_reg     <= blank_next;
            dirty_reg     <= dirty_next;
            sweep_reg     <= sweep_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `TTG_ASSERT(a_cursor_in_grid, state_reg == ST_IDLE, 7'(row_reg) < act_rows_reg,
                "cursor row outside the active grid")
    `TTG_ASSERT(a_pop_needs_room, item_pop, !out_valid_reg || m_tready,
                "item taken while the result register is full")
    `TTG_ASSERT_NEXT(a_sweep_ends_in_print,
                     state_reg == ST_SWEEP && sweep_reg == CW'(MAX_COLUMNS - 1),
                     state_reg == ST_PRINT &&
                     !blank_reg[phys_row(row_reg, off_reg, act_rows_reg)],
                     "row fill did not hand over to the write")

endmodule

// ===== design/text_terminal_grid_core.sv =====
// Top level of the text terminal grid: configuration registers, front queue and back sequencer.
// Depends on ttg_pkg, ttg_front and ttg_back.
//
// Each beat on the slave side yields exactly one result beat, in order. Beats are classified
// and held in a two-entry queue, which the back sequencer reads from the cycle after a beat is
// accepted; it takes a beat only when its result register is free or being emptied, and the
// result leaves the cycle after the sequencer finishes. Queries, marks, CR, LF, backspace,
// dropped bytes and unused opcodes finish in the idle state; a cell read passes through the
// read state, a printable byte through the print and wrap states. A tab writes a space in each
// tab state step, then goes to the wrap state. Form feed and initialise step through the clear
// state once per active row. Scrolls advance a row offset and mark the freed row blank in the
// cycle that moves the cursor. The first printable byte into a blanked row first fills that row
// of the character memory with spaces; it has one write port. No clearing pass runs after reset.
module text_terminal_grid_core #(
    parameter int MAX_COLUMNS = ttg_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = ttg_pkg::DEF_MAX_ROWS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ttg_pkg::IN_DATA_W-1:0]   s_tdata,   // data_byte, target_row, target_column
    input  logic [2:0]                      s_tuser,   // opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // cell_char, row_dirty, cursor_y, cursor_x, scroll_count, bytes_count
    output logic [ttg_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [7:0]                      cfg_data
);

    logic [7:0]         grid_columns_reg;
    logic [6:0]         grid_rows_reg;
    ttg_pkg::ttg_item_t head;
    logic               head_valid;
    logic               pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_columns_reg <= 8'(ttg_pkg::RESET_COLUMNS);
            grid_rows_reg    <= 7'(ttg_pkg::RESET_ROWS);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ttg_pkg::CFG_COLUMNS: grid_columns_reg <= cfg_data;
                ttg_pkg::CFG_ROWS:    grid_rows_reg    <= cfg_data[6:0];
                default:              ;
            endcase
        end
    end

    ttg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    ttg_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (head),
        .item_valid   (head_valid),
        .item_pop     (pop),
        .grid_columns (grid_columns_reg),
        .grid_rows    (grid_rows_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule
